>>> hdl/fsat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsat_pkg;

  // Table geometry
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned USED_W   = $clog2(CAPACITY + 1);

  // Field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned PKTS_W  = 32;
  localparam int unsigned BYTES_W = 48;
  localparam int unsigned CNT_W   = PKTS_W + BYTES_W;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cap_in;       // latch the accepted request
    logic lookup_rd;    // read counters of the matching group
    logic upd_wr;       // write back the bumped counters
    logic append;       // store a new group
    logic append_zero;  // new group goes to entry 0 and the table restarts
    logic flush_clr;    // rewind the flush pointer
    logic flush_rd;     // read counters at the flush pointer
    logic out_load;     // load the output register with the flushed group
    logic flush_inc;    // advance the flush pointer
  } fsat_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;
    logic full;
    logic flush_last;
    logic out_free;
  } fsat_sts_t;

endpackage

`default_nettype wire

>>> hdl/fsat_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fsat_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fsat_pkg::fsat_sts_t sts_i,
  output fsat_pkg::fsat_cmd_t cmd_o
);
  import fsat_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_LOOK     = 5'b00010,
    S_UPD      = 5'b00100,
    S_FLUSH_RD = 5'b01000,
    S_FLUSH_LD = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Sequence lookup, update, append and flush
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts_i.hit) begin
          cmd_o.lookup_rd = 1'b1;
          state_d         = S_UPD;
        end else if (!sts_i.full) begin
          cmd_o.append = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.flush_clr = 1'b1;
          state_d         = S_FLUSH_RD;
        end
      end
      S_UPD: begin
        cmd_o.upd_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_FLUSH_RD: begin
        cmd_o.flush_rd = 1'b1;
        state_d        = S_FLUSH_LD;
      end
      S_FLUSH_LD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.flush_last) begin
            cmd_o.append      = 1'b1;
            cmd_o.append_zero = 1'b1;
            state_d           = S_IDLE;
          end else begin
            cmd_o.flush_inc = 1'b1;
            state_d         = S_FLUSH_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/fsat_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module fsat_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fsat_pkg::fsat_cmd_t                 cmd_i,
  output fsat_pkg::fsat_sts_t                 sts_o,
  input  logic [fsat_pkg::ADDR_W-1:0]         src_addr_i,
  input  logic [fsat_pkg::ADDR_W-1:0]         dst_addr_i,
  input  logic [fsat_pkg::PORT_W-1:0]         dst_port_i,
  input  logic [fsat_pkg::LEN_W-1:0]          pkt_len_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [fsat_pkg::ADDR_W-1:0]         rec_src_addr_o,
  output logic [fsat_pkg::ADDR_W-1:0]         rec_dst_addr_o,
  output logic [fsat_pkg::PORT_W-1:0]         rec_dst_port_o,
  output logic [fsat_pkg::PKTS_W-1:0]         rec_pkt_count_o,
  output logic [fsat_pkg::BYTES_W-1:0]        rec_byte_count_o,
  output logic                                rec_last_o
);
  import fsat_pkg::*;

  // Latched request
  logic [ADDR_W-1:0] src_in_q, dst_in_q;
  logic [PORT_W-1:0] port_in_q;
  logic [LEN_W-1:0]  len_in_q;

  // Key lanes, one per group
  logic [ADDR_W-1:0] key_src_q  [CAPACITY];
  logic [ADDR_W-1:0] key_dst_q  [CAPACITY];
  logic [PORT_W-1:0] key_port_q [CAPACITY];

  // Counter memory: {packets, bytes}
  logic [CNT_W-1:0]  cnt_mem [CAPACITY];
  logic [CNT_W-1:0]  rd_q;

  logic [USED_W-1:0] used_q;
  logic [IDX_W-1:0]  hit_idx_q, flush_idx_q;
  logic              out_valid_q;

  logic [CAPACITY-1:0] lane_hit;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr, app_addr;
  logic [CNT_W-1:0]  wr_data;

  logic [PKTS_W:0]   pkts_sum;
  logic [BYTES_W:0]  bytes_sum;
  logic [PKTS_W-1:0] pkts_new;
  logic [BYTES_W-1:0] bytes_new;

  // Compare the key against every valid lane
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lane_hit[i] = (USED_W'(i) < used_q) && (key_src_q[i] == src_in_q) &&
                    (key_dst_q[i] == dst_in_q) && (key_port_q[i] == port_in_q);
    end
  end

  // Pick the lowest matching lane
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (lane_hit[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign sts_o.hit        = hit;
  assign sts_o.full       = (used_q == USED_W'(CAPACITY));
  assign sts_o.flush_last = (flush_idx_q == IDX_W'(CAPACITY - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Saturating counter update
  assign pkts_sum  = {1'b0, rd_q[CNT_W-1:BYTES_W]} + (PKTS_W + 1)'(1);
  assign bytes_sum = {1'b0, rd_q[BYTES_W-1:0]} + (BYTES_W + 1)'(len_in_q);
  assign pkts_new  = pkts_sum[PKTS_W]   ? '1 : pkts_sum[PKTS_W-1:0];
  assign bytes_new = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];

  // Memory port selection
  assign app_addr = cmd_i.append_zero ? '0 : used_q[IDX_W-1:0];
  assign rd_en    = cmd_i.lookup_rd | cmd_i.flush_rd;
  assign rd_addr  = cmd_i.flush_rd ? flush_idx_q : hit_idx;
  assign wr_en    = cmd_i.upd_wr | cmd_i.append;
  assign wr_addr  = cmd_i.upd_wr ? hit_idx_q : app_addr;
  assign wr_data  = cmd_i.upd_wr ? {pkts_new, bytes_new}
                                 : {PKTS_W'(1), BYTES_W'(len_in_q)};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= cnt_mem[rd_addr];
    end
  end

  // Capture the request, store keys, hold the hit lane
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      src_in_q  <= src_addr_i;
      dst_in_q  <= dst_addr_i;
      port_in_q <= dst_port_i;
      len_in_q  <= pkt_len_i;
    end
    if (cmd_i.append) begin
      key_src_q[app_addr]  <= src_in_q;
      key_dst_q[app_addr]  <= dst_in_q;
      key_port_q[app_addr] <= port_in_q;
    end
    if (cmd_i.lookup_rd) begin
      hit_idx_q <= hit_idx;
    end
  end

  // Output record register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rec_src_addr_o   <= key_src_q[flush_idx_q];
      rec_dst_addr_o   <= key_dst_q[flush_idx_q];
      rec_dst_port_o   <= key_port_q[flush_idx_q];
      rec_pkt_count_o  <= rd_q[CNT_W-1:BYTES_W];
      rec_byte_count_o <= rd_q[BYTES_W-1:0];
      rec_last_o       <= sts_o.flush_last;
    end
  end

  // Group count, flush pointer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      flush_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.append) begin
        used_q <= cmd_i.append_zero ? USED_W'(1) : used_q + USED_W'(1);
      end
      if (cmd_i.flush_clr) begin
        flush_idx_q <= '0;
      end else if (cmd_i.flush_inc) begin
        flush_idx_q <= flush_idx_q + IDX_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(CAPACITY))
    else $error("group count beyond capacity");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append && !cmd_i.append_zero |-> used_q < USED_W'(CAPACITY))
    else $error("append into a full table");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output record overwritten before taken");

  a_upd_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd_wr |-> $past(cmd_i.lookup_rd))
    else $error("counter write-back without a lookup read");

endmodule

`default_nettype wire

>>> hdl/flow_stats_aggregation_table.sv
// Flow statistics aggregation table.
// Input channel (in_valid_i/in_ready_o) takes one packet request: source
// address, destination address, destination port and length. The key is
// compared against all stored groups in parallel. A hit bumps the group's
// packet and byte counters (both saturate). A miss appends a new group; a
// miss on a full table first flushes every group, in insertion order, on the
// output channel (out_valid_o/out_ready_i), rec_last_o marking the final one,
// and then starts the table over with the new group.
// Steps: a hit is accepted, compared with its counters read, and written
// back; a miss that appends is accepted, then compared and stored. The
// registered read of the counter memory adds the write-back step. A flush
// reads each record's counters, then loads it into the output register; the
// input stays not ready meanwhile and until each request is finished.
// The output record sits in a register: the last flushed record may still
// wait there while the next request is accepted. A stalled receiver holds
// the flush at the current record.
// Reset empties the table and the output register; no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none

module flow_stats_aggregation_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fsat_pkg::ADDR_W-1:0]    src_addr_i,
  input  logic [fsat_pkg::ADDR_W-1:0]    dst_addr_i,
  input  logic [fsat_pkg::PORT_W-1:0]    dst_port_i,
  input  logic [fsat_pkg::LEN_W-1:0]     pkt_len_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fsat_pkg::ADDR_W-1:0]    rec_src_addr_o,
  output logic [fsat_pkg::ADDR_W-1:0]    rec_dst_addr_o,
  output logic [fsat_pkg::PORT_W-1:0]    rec_dst_port_o,
  output logic [fsat_pkg::PKTS_W-1:0]    rec_pkt_count_o,
  output logic [fsat_pkg::BYTES_W-1:0]   rec_byte_count_o,
  output logic                           rec_last_o
);
  import fsat_pkg::*;

  fsat_cmd_t cmd;
  fsat_sts_t sts;

  // Controller
  fsat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  fsat_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .src_addr_i       (src_addr_i),
    .dst_addr_i       (dst_addr_i),
    .dst_port_i       (dst_port_i),
    .pkt_len_i        (pkt_len_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .rec_src_addr_o   (rec_src_addr_o),
    .rec_dst_addr_o   (rec_dst_addr_o),
    .rec_dst_port_o   (rec_dst_port_o),
    .rec_pkt_count_o  (rec_pkt_count_o),
    .rec_byte_count_o (rec_byte_count_o),
    .rec_last_o       (rec_last_o)
  );

endmodule

`default_nettype wire
